[design/assert_macros.svh]
// Assertion helpers; every use sits in a module with clock and reset ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PRES_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define PRES_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pres_pkg.sv]
package pres_pkg;

   localparam int TAPS       = 8;
   localparam int PHASES     = 32;
   localparam int MAX_OUT    = 10;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = PROD_W + 3;
   localparam int POS_W      = 20;
   localparam int FRAC_W     = 16;
   localparam int TAP_IDX_W  = $clog2(TAPS);
   localparam int PHASE_W    = $clog2(PHASES);
   localparam int RND_SHIFT  = 14;
   localparam int RND_BIAS   = 1 << (RND_SHIFT - 1);

   localparam logic [POS_W-1:0] POS_RESET  = POS_W'(8 * 65536);
   localparam logic [POS_W-1:0] STEP_RESET = POS_W'(65536);

   typedef struct packed {
      logic start;
      logic add;
   } mac_ctl_type;

   localparam logic signed [COEF_W-1:0] COEF_ROM [PHASES][TAPS] = '{
      '{ 16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000,
         16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      '{-16'sh000a, 16'sh0052,-16'sh0179, 16'sh3fe2,
         16'sh019f,-16'sh005b, 16'sh000c, 16'sh0000},
      '{-16'sh0013, 16'sh009c,-16'sh02cc, 16'sh3f86,
         16'sh0362,-16'sh00c0, 16'sh001a, 16'sh0000},
      '{-16'sh001a, 16'sh00dc,-16'sh03f9, 16'sh3eef,
         16'sh054a,-16'sh012c, 16'sh002b, 16'sh0000},
      '{-16'sh001f, 16'sh0113,-16'sh0500, 16'sh3e1d,
         16'sh0753,-16'sh01a0, 16'sh003d, 16'sh0000},
      '{-16'sh0023, 16'sh0141,-16'sh05e1, 16'sh3d12,
         16'sh097c,-16'sh021a, 16'sh0050,-16'sh0001},
      '{-16'sh0026, 16'sh0166,-16'sh069e, 16'sh3bd0,
         16'sh0bc4,-16'sh029a, 16'sh0066,-16'sh0001},
      '{-16'sh0027, 16'sh0182,-16'sh0738, 16'sh3a5a,
         16'sh0e27,-16'sh031f, 16'sh007d,-16'sh0002},
      '{-16'sh0028, 16'sh0197,-16'sh07b0, 16'sh38b2,
         16'sh10a2,-16'sh03a7, 16'sh0096,-16'sh0003},
      '{-16'sh0027, 16'sh01a5,-16'sh0807, 16'sh36dc,
         16'sh1333,-16'sh0430, 16'sh00af,-16'sh0005},
      '{-16'sh0026, 16'sh01ab,-16'sh083f, 16'sh34db,
         16'sh15d5,-16'sh04ba, 16'sh00ca,-16'sh0007},
      '{-16'sh0024, 16'sh01ac,-16'sh085b, 16'sh32b3,
         16'sh1886,-16'sh0541, 16'sh00e5,-16'sh0008},
      '{-16'sh0022, 16'sh01a6,-16'sh085d, 16'sh3068,
         16'sh1b40,-16'sh05c6, 16'sh0101,-16'sh000b},
      '{-16'sh001f, 16'sh019c,-16'sh0846, 16'sh2dfe,
         16'sh1e00,-16'sh0644, 16'sh011c,-16'sh000d},
      '{-16'sh001c, 16'sh018e,-16'sh0819, 16'sh2b7a,
         16'sh20c1,-16'sh06bb, 16'sh0136,-16'sh0010},
      '{-16'sh0019, 16'sh017c,-16'sh07d9, 16'sh28e1,
         16'sh2380,-16'sh0727, 16'sh014f,-16'sh0013},
      '{-16'sh0016, 16'sh0167,-16'sh0788, 16'sh2637,
         16'sh2637,-16'sh0788, 16'sh0167,-16'sh0016},
      '{-16'sh0013, 16'sh014f,-16'sh0727, 16'sh2380,
         16'sh28e1,-16'sh07d9, 16'sh017c,-16'sh0019},
      '{-16'sh0010, 16'sh0136,-16'sh06bb, 16'sh20c1,
         16'sh2b7a,-16'sh0819, 16'sh018e,-16'sh001c},
      '{-16'sh000d, 16'sh011c,-16'sh0644, 16'sh1e00,
         16'sh2dfe,-16'sh0846, 16'sh019c,-16'sh001f},
      '{-16'sh000b, 16'sh0101,-16'sh05c6, 16'sh1b40,
         16'sh3068,-16'sh085d, 16'sh01a6,-16'sh0022},
      '{-16'sh0008, 16'sh00e5,-16'sh0541, 16'sh1886,
         16'sh32b3,-16'sh085b, 16'sh01ac,-16'sh0024},
      '{-16'sh0007, 16'sh00ca,-16'sh04ba, 16'sh15d5,
         16'sh34db,-16'sh083f, 16'sh01ab,-16'sh0026},
      '{-16'sh0005, 16'sh00af,-16'sh0430, 16'sh1333,
         16'sh36dc,-16'sh0807, 16'sh01a5,-16'sh0027},
      '{-16'sh0003, 16'sh0096,-16'sh03a7, 16'sh10a2,
         16'sh38b2,-16'sh07b0, 16'sh0197,-16'sh0028},
      '{-16'sh0002, 16'sh007d,-16'sh031f, 16'sh0e27,
         16'sh3a5a,-16'sh0738, 16'sh0182,-16'sh0027},
      '{-16'sh0001, 16'sh0066,-16'sh029a, 16'sh0bc4,
         16'sh3bd0,-16'sh069e, 16'sh0166,-16'sh0026},
      '{-16'sh0001, 16'sh0050,-16'sh021a, 16'sh097c,
         16'sh3d12,-16'sh05e1, 16'sh0141,-16'sh0023},
      '{ 16'sh0000, 16'sh003d,-16'sh01a0, 16'sh0753,
         16'sh3e1d,-16'sh0500, 16'sh0113,-16'sh001f},
      '{ 16'sh0000, 16'sh002b,-16'sh012c, 16'sh054a,
         16'sh3eef,-16'sh03f9, 16'sh00dc,-16'sh001a},
      '{ 16'sh0000, 16'sh001a,-16'sh00c0, 16'sh0362,
         16'sh3f86,-16'sh02cc, 16'sh009c,-16'sh0013},
      '{ 16'sh0000, 16'sh000c,-16'sh005b, 16'sh019f,
         16'sh3fe2,-16'sh0179, 16'sh0052,-16'sh000a}
   };

   function automatic logic signed [COEF_W-1:0] coef_at(
      input logic [PHASE_W-1:0]   phase,
      input logic [TAP_IDX_W-1:0] tap
   );
      return COEF_ROM[phase][tap];
   endfunction

endpackage

[design/pres_mac.sv]
module pres_mac (
   input  logic                                  clock,
   input  pres_pkg::mac_ctl_type                 ctl,
   input  logic signed [pres_pkg::SAMPLE_W-1:0]  sample,
   input  logic signed [pres_pkg::COEF_W-1:0]    coef,
   output logic signed [pres_pkg::ACC_W-1:0]     acc
);
   import pres_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   always_comb begin
      prod_in = PROD_W'(sample) * PROD_W'(coef);
      if (ctl.start) begin
         acc_in = '0;
      end else if (ctl.add) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

[design/polyphase_audio_resampler_core.sv]
// Per output: ST_MAC feeds every tap through one shared 16x16 multiply-accumulate
// unit (registered product, then accumulate), then ST_EMIT rounds, saturates and registers it.
// A sample that causes n outputs (0..10) holds req_tready low until the last of
// them is registered, also while a finished result waits on rsp_tready.
// Synchronous active-high reset: window cleared, position 8.0, step 1.0.
`include "assert_macros.svh"

module polyphase_audio_resampler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] sample_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [15:0] sample_out
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [19:0] csr_data
);
   import pres_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MAC  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   localparam int TAP_CNT_W = $clog2(TAPS + 1);
   localparam int OUT_CNT_W = $clog2(MAX_OUT);
   localparam int Q_W       = ACC_W + 1 - RND_SHIFT;

   state_type                   state_ff, state_in;
   logic signed [SAMPLE_W-1:0]  window_ff [TAPS];
   logic signed [SAMPLE_W-1:0]  window_in [TAPS];
   logic [POS_W-1:0]            pos_ff, pos_in;
   logic [POS_W-1:0]            step_ff, step_in;
   logic [TAP_CNT_W-1:0]        tap_ff, tap_in;
   logic [OUT_CNT_W-1:0]        n_ff, n_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        req_fire;
   logic                        emit_go;
   logic [POS_W-1:0]            pos_back;
   logic [POS_W:0]              pos_sum;
   logic [POS_W-1:0]            pos_next;
   logic                        is_last;
   mac_ctl_type                 mac_ctl;
   logic signed [ACC_W-1:0]     acc;
   logic signed [ACC_W:0]       biased;
   logic signed [Q_W-1:0]       q;
   logic [SAMPLE_W-1:0]         sat;

   pres_mac u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .sample (window_ff[tap_ff[TAP_IDX_W-1:0]]),
      .coef   (coef_at(pos_ff[FRAC_W-1 -: PHASE_W], tap_ff[TAP_IDX_W-1:0])),
      .acc    (acc)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign emit_go    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   assign mac_ctl = '{start: (state_ff == ST_MAC) && (tap_ff == '0),
                      add:   (state_ff == ST_MAC) && (tap_ff != '0)};

   // integer part saturates at zero on the move back
   assign pos_back = (pos_ff[POS_W-1:FRAC_W] != '0) ?
                     {pos_ff[POS_W-1:FRAC_W] - 1'b1, pos_ff[FRAC_W-1:0]} : pos_ff;
   assign pos_sum  = {1'b0, pos_ff} + {1'b0, step_ff};
   assign pos_next = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
   assign is_last  = (n_ff == OUT_CNT_W'(MAX_OUT - 1)) ||
                     (pos_next[POS_W-1:FRAC_W] != '0);

   assign biased = {acc[ACC_W-1], acc} + (ACC_W+1)'(RND_BIAS);
   assign q      = biased[ACC_W:RND_SHIFT];

   always_comb begin
      priority if (q > Q_W'(32767)) begin
         sat = 16'h7fff;
      end else if (q < -Q_W'(32768)) begin
         sat = 16'h8000;
      end else begin
         sat = q[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      tap_in       = tap_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         step_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               for (int k = 0; k < TAPS - 1; k++) begin
                  window_in[k] = window_ff[k + 1];
               end
               window_in[TAPS - 1] = req_tdata;
               pos_in = pos_back;
               n_in   = '0;
               tap_in = '0;
               if (pos_back[POS_W-1:FRAC_W] == '0) begin
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            if (tap_ff == TAP_CNT_W'(TAPS)) begin
               state_in = ST_EMIT;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat;
               rsp_last_in  = is_last;
               pos_in       = pos_next;
               tap_in       = '0;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  n_in     = n_ff + 1'b1;
                  state_in = ST_MAC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= '{default: '0};
         pos_ff       <= POS_RESET;
         step_ff      <= STEP_RESET;
         tap_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         pos_ff       <= pos_in;
         step_ff      <= step_in;
         tap_ff       <= tap_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `PRES_ASSERT_IMPLY(a_pos_below_one, state_ff != ST_IDLE, pos_ff[POS_W-1:FRAC_W] == '0, "position integer part nonzero during output work")
   `PRES_ASSERT_IMPLY(a_out_count, state_ff != ST_IDLE, n_ff <= OUT_CNT_W'(MAX_OUT - 1), "output count past limit")
   `PRES_ASSERT_IMPLY(a_tap_count, state_ff == ST_MAC, tap_ff <= TAP_CNT_W'(TAPS), "tap counter past last tap")
   `PRES_ASSERT_NEXT(a_last_ends, emit_go && is_last, state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff, "last result did not end the transaction")

endmodule
